/* rtl/pnn_pkg.sv */
package pnn_pkg;

    // Capacity and fixed-point formats.
    localparam int MAX_CANDIDATES  = 4096;
    localparam int COORD_FRAC_BITS = 10;
    localparam int INV_FRAC_BITS   = 20;
    localparam int POS_W           = $clog2(MAX_CANDIDATES);
    localparam int CNT_W           = $clog2(MAX_CANDIDATES + 1);
    localparam int IDX_W           = 12;
    localparam int COORD_W         = 21;
    localparam int DIFF_W          = 22;
    localparam int ENTRY_W         = 21;
    localparam int REG_W           = 63;
    localparam int OPND_W          = 25;
    localparam int ACC_W           = 50;
    localparam int REM_W           = 24;
    localparam int CART_W          = 24;
    localparam int SQ_W            = 43;
    localparam int ROOT_W          = 44;
    localparam int DIST_W          = 21;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W       = 3;

    localparam logic [SQ_W-1:0]          SQ_MAX     = {SQ_W{1'b1}};
    localparam logic [DIST_W-1:0]        DIST_MAX   = {DIST_W{1'b1}};
    localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(64'sd1 <<< (INV_FRAC_BITS - 1));
    localparam logic [ROOT_W-1:0]        SQRT_BIT0  = ROOT_W'(64'd1 << (SQ_W - 1));

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_ROW_X  = 3'd0,
        CFG_BOX_ROW_Y  = 3'd1,
        CFG_BOX_ROW_Z  = 3'd2,
        CFG_FRAC_COL_X = 3'd3,
        CFG_FRAC_COL_Y = 3'd4,
        CFG_FRAC_COL_Z = 3'd5
    } cfg_idx_t;

    typedef logic [2:0][REG_W-1:0] mat_t;

    typedef struct packed {
        mat_t box;
        mat_t frac;
    } cfg_t;

    // One queued request: displacement and end-of-run mark.
    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dz;
        logic                     last;
    } qentry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_ROUND,
        ST_KEEP,
        ST_SQRT,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        PH_FRAC,
        PH_BOX,
        PH_SQ
    } phase_t;

    // Signed 21-bit entry c of a packed matrix register.
    function automatic logic signed [ENTRY_W-1:0] entry(input logic [REG_W-1:0] w,
                                                        input logic [1:0] c);
        logic signed [ENTRY_W-1:0] e;
        case (c)
            2'd0:    e = w[20:0];
            2'd1:    e = w[41:21];
            default: e = w[62:42];
        endcase
        return e;
    endfunction

endpackage

/* rtl/pnn_if.sv */
interface pnn_item_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [pnn_pkg::COORD_W-1:0]      query_x;
    logic signed [pnn_pkg::COORD_W-1:0]      query_y;
    logic signed [pnn_pkg::COORD_W-1:0]      query_z;
    logic signed [pnn_pkg::COORD_W-1:0]      cand_x;
    logic signed [pnn_pkg::COORD_W-1:0]      cand_y;
    logic signed [pnn_pkg::COORD_W-1:0]      cand_z;
    logic                                    last_candidate;

    modport source (output valid, query_x, query_y, query_z, cand_x, cand_y, cand_z,
                    last_candidate, input ready);
    modport sink (input valid, query_x, query_y, query_z, cand_x, cand_y, cand_z,
                  last_candidate, output ready);
endinterface

interface pnn_result_if;
    logic                          valid;
    logic                          ready;
    logic [pnn_pkg::IDX_W-1:0]     nearest_index;
    logic [pnn_pkg::DIST_W-1:0]    nearest_distance;
    logic                          count_overflow;

    modport source (output valid, nearest_index, nearest_distance, count_overflow,
                    input ready);
    modport sink (input valid, nearest_index, nearest_distance, count_overflow,
                  output ready);
endinterface

interface pnn_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pnn_pkg::CFG_IDX_W-1:0]     index;
    logic [pnn_pkg::REG_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/pnn_front.sv */
module pnn_front
(
    input  logic               clk,
    input  logic               rst_n,
    pnn_item_if.sink           item,
    output logic               q_valid,
    output pnn_pkg::qentry_t   q_data,
    input  logic               q_pop
);

    pnn_pkg::qentry_t                 mem_reg [pnn_pkg::QUEUE_DEPTH];
    logic [pnn_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [pnn_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [pnn_pkg::QFILL_W-1:0]      fill_reg;
    logic [pnn_pkg::QFILL_W-1:0]      fill_next;
    logic                             push;
    logic                             pop;
    pnn_pkg::qentry_t                 entry_new;

    // The displacement is formed as the request comes in.
    always_comb
    begin
        entry_new.dx   = pnn_pkg::DIFF_W'(item.query_x) - pnn_pkg::DIFF_W'(item.cand_x);
        entry_new.dy   = pnn_pkg::DIFF_W'(item.query_y) - pnn_pkg::DIFF_W'(item.cand_y);
        entry_new.dz   = pnn_pkg::DIFF_W'(item.query_z) - pnn_pkg::DIFF_W'(item.cand_z);
        entry_new.last = item.last_candidate;
    end

    assign item.ready = (fill_reg != pnn_pkg::QFILL_W'(pnn_pkg::QUEUE_DEPTH));
    assign push       = item.valid && item.ready;
    assign q_valid    = (fill_reg != '0);
    assign pop        = q_pop && q_valid;
    assign q_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry_new;
        end
    end

endmodule

/* rtl/pnn_back.sv */
module pnn_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  pnn_pkg::cfg_t      cfg,
    input  logic               q_valid,
    input  pnn_pkg::qentry_t   q_data,
    output logic               q_pop,
    pnn_result_if.source       result
);

    pnn_pkg::state_t                       state_reg;
    pnn_pkg::state_t                       state_next;
    pnn_pkg::phase_t                       phase_reg;
    logic [1:0]                            k_reg;
    logic [1:0]                            c_reg;
    logic signed [pnn_pkg::DIFF_W-1:0]     d_reg [3];
    logic                                  last_reg;
    logic signed [pnn_pkg::ACC_W-1:0]      acc_reg;
    logic signed [pnn_pkg::ACC_W-1:0]      prod_reg;
    logic signed [pnn_pkg::REM_W-1:0]      r_reg [3];
    logic signed [pnn_pkg::CART_W-1:0]     v_reg [3];
    logic signed [pnn_pkg::OPND_W-1:0]     op_a;
    logic signed [pnn_pkg::OPND_W-1:0]     op_b;

    logic signed [pnn_pkg::ACC_W-1:0]      f_val;
    logic signed [pnn_pkg::ACC_W-1:0]      n_val;
    logic signed [pnn_pkg::ACC_W-1:0]      r_val;
    logic signed [pnn_pkg::ACC_W-1:0]      v_val;

    logic [pnn_pkg::SQ_W-1:0]              best_reg;
    logic [pnn_pkg::POS_W-1:0]             pos_reg;
    logic [pnn_pkg::CNT_W-1:0]             count_reg;
    logic                                  overflow_reg;
    logic [pnn_pkg::SQ_W-1:0]              sq_sat;
    logic                                  in_cap;
    logic                                  take;
    logic [pnn_pkg::SQ_W-1:0]              best_next;
    logic [pnn_pkg::POS_W-1:0]             pos_next;
    logic                                  overflow_next;

    logic [pnn_pkg::ROOT_W-1:0]            rem_reg;
    logic [pnn_pkg::ROOT_W-1:0]            root_reg;
    logic [pnn_pkg::ROOT_W-1:0]            bit_reg;
    logic [pnn_pkg::ROOT_W-1:0]            trial;
    logic [pnn_pkg::ROOT_W-1:0]            q_round;
    logic [pnn_pkg::DIST_W-1:0]            dist_val;
    logic [pnn_pkg::IDX_W-1:0]             res_idx_reg;
    logic                                  res_ovf_reg;

    logic                                  out_valid_reg;
    logic [pnn_pkg::IDX_W-1:0]             out_idx_reg;
    logic [pnn_pkg::DIST_W-1:0]            out_dist_reg;
    logic                                  out_ovf_reg;
    logic                                  out_free;
    logic                                  out_load;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (phase_reg)
            pnn_pkg::PH_FRAC:
            begin
                op_a = pnn_pkg::OPND_W'(d_reg[c_reg]);
                op_b = pnn_pkg::OPND_W'(pnn_pkg::entry(cfg.frac[k_reg], c_reg));
            end
            pnn_pkg::PH_BOX:
            begin
                op_a = pnn_pkg::OPND_W'(pnn_pkg::entry(cfg.box[k_reg], c_reg));
                op_b = pnn_pkg::OPND_W'(r_reg[c_reg]);
            end
            pnn_pkg::PH_SQ:
            begin
                op_a = pnn_pkg::OPND_W'(v_reg[k_reg]);
                op_b = pnn_pkg::OPND_W'(v_reg[k_reg]);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Wrap the fractional coordinate and round the Cartesian component.
    always_comb
    begin
        f_val = acc_reg >>> pnn_pkg::COORD_FRAC_BITS;
        if (f_val >= 0)
        begin
            n_val = (f_val + pnn_pkg::ROUND_HALF) >>> pnn_pkg::INV_FRAC_BITS;
        end
        else
        begin
            n_val = -((-f_val + pnn_pkg::ROUND_HALF) >>> pnn_pkg::INV_FRAC_BITS);
        end
        r_val = f_val - (n_val <<< pnn_pkg::INV_FRAC_BITS);
        v_val = (acc_reg + pnn_pkg::ROUND_HALF) >>> pnn_pkg::INV_FRAC_BITS;
    end

    // Compare against the running best; first minimum wins.
    always_comb
    begin
        if (unsigned'(acc_reg) > pnn_pkg::ACC_W'(pnn_pkg::SQ_MAX))
        begin
            sq_sat = pnn_pkg::SQ_MAX;
        end
        else
        begin
            sq_sat = acc_reg[pnn_pkg::SQ_W-1:0];
        end
        in_cap        = (count_reg < pnn_pkg::CNT_W'(pnn_pkg::MAX_CANDIDATES));
        take          = in_cap && ((count_reg == '0) || (sq_sat < best_reg));
        best_next     = take ? sq_sat : best_reg;
        pos_next      = take ? count_reg[pnn_pkg::POS_W-1:0] : pos_reg;
        overflow_next = overflow_reg || !in_cap;
    end

    // Square root step and final rounding.
    always_comb
    begin
        trial   = root_reg + bit_reg;
        q_round = root_reg + pnn_pkg::ROOT_W'(rem_reg > root_reg);
        if (q_round > pnn_pkg::ROOT_W'(pnn_pkg::DIST_MAX))
        begin
            dist_val = pnn_pkg::DIST_MAX;
        end
        else
        begin
            dist_val = q_round[pnn_pkg::DIST_W-1:0];
        end
    end

    assign out_free = !out_valid_reg || result.ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pnn_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = pnn_pkg::ST_MUL;
                end
            end
            pnn_pkg::ST_MUL:
            begin
                state_next = pnn_pkg::ST_ADD;
            end
            pnn_pkg::ST_ADD:
            begin
                if (phase_reg == pnn_pkg::PH_SQ)
                begin
                    state_next = (k_reg == 2'd2) ? pnn_pkg::ST_KEEP : pnn_pkg::ST_MUL;
                end
                else
                begin
                    state_next = (c_reg == 2'd2) ? pnn_pkg::ST_ROUND : pnn_pkg::ST_MUL;
                end
            end
            pnn_pkg::ST_ROUND:
            begin
                state_next = pnn_pkg::ST_MUL;
            end
            pnn_pkg::ST_KEEP:
            begin
                state_next = last_reg ? pnn_pkg::ST_SQRT : pnn_pkg::ST_IDLE;
            end
            pnn_pkg::ST_SQRT:
            begin
                if (bit_reg[0])
                begin
                    state_next = pnn_pkg::ST_FIN;
                end
            end
            pnn_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = pnn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pnn_pkg::ST_IDLE;
            end
        endcase
    end

    // State machine outputs.
    always_comb
    begin
        q_pop    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            pnn_pkg::ST_IDLE: q_pop    = q_valid;
            pnn_pkg::ST_FIN:  out_load = out_free;
            default:
            begin
                q_pop    = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    // Control and run state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pnn_pkg::ST_IDLE;
            phase_reg     <= pnn_pkg::PH_FRAC;
            k_reg         <= '0;
            c_reg         <= '0;
            best_reg      <= pnn_pkg::SQ_MAX;
            pos_reg       <= '0;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                pnn_pkg::ST_IDLE:
                begin
                    phase_reg <= pnn_pkg::PH_FRAC;
                    k_reg     <= '0;
                    c_reg     <= '0;
                end
                pnn_pkg::ST_ADD:
                begin
                    if (phase_reg == pnn_pkg::PH_SQ)
                    begin
                        if (k_reg != 2'd2)
                        begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                    else if (c_reg != 2'd2)
                    begin
                        c_reg <= c_reg + 1'b1;
                    end
                end
                pnn_pkg::ST_ROUND:
                begin
                    c_reg <= '0;
                    if (k_reg == 2'd2)
                    begin
                        k_reg     <= '0;
                        phase_reg <= (phase_reg == pnn_pkg::PH_FRAC) ?
                                     pnn_pkg::PH_BOX : pnn_pkg::PH_SQ;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                pnn_pkg::ST_KEEP:
                begin
                    if (last_reg)
                    begin
                        best_reg     <= pnn_pkg::SQ_MAX;
                        pos_reg      <= '0;
                        count_reg    <= '0;
                        overflow_reg <= 1'b0;
                    end
                    else
                    begin
                        best_reg     <= best_next;
                        pos_reg      <= pos_next;
                        overflow_reg <= overflow_next;
                        if (in_cap)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            pnn_pkg::ST_IDLE:
            begin
                d_reg[0] <= q_data.dx;
                d_reg[1] <= q_data.dy;
                d_reg[2] <= q_data.dz;
                last_reg <= q_data.last;
                acc_reg  <= '0;
            end
            pnn_pkg::ST_MUL:
            begin
                prod_reg <= op_a * op_b;
            end
            pnn_pkg::ST_ADD:
            begin
                acc_reg <= acc_reg + prod_reg;
            end
            pnn_pkg::ST_ROUND:
            begin
                acc_reg <= '0;
                if (phase_reg == pnn_pkg::PH_FRAC)
                begin
                    r_reg[k_reg] <= pnn_pkg::REM_W'(r_val);
                end
                else
                begin
                    v_reg[k_reg] <= pnn_pkg::CART_W'(v_val);
                end
            end
            pnn_pkg::ST_KEEP:
            begin
                rem_reg     <= pnn_pkg::ROOT_W'(best_next);
                root_reg    <= '0;
                bit_reg     <= pnn_pkg::SQRT_BIT0;
                res_idx_reg <= pnn_pkg::IDX_W'(pos_next);
                res_ovf_reg <= overflow_next;
            end
            pnn_pkg::ST_SQRT:
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_idx_reg  <= res_idx_reg;
            out_dist_reg <= dist_val;
            out_ovf_reg  <= res_ovf_reg;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.nearest_index    = out_idx_reg;
    assign result.nearest_distance = out_dist_reg;
    assign result.count_overflow   = out_ovf_reg;

    // Checks on the sequencer.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pnn_pkg::CNT_W'(pnn_pkg::MAX_CANDIDATES))
        else $error("candidate count beyond capacity");

    a_mul_then_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pnn_pkg::ST_MUL) |=> (state_reg == pnn_pkg::ST_ADD))
        else $error("product not accumulated after multiply");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == pnn_pkg::ST_FIN))
        else $error("result raised outside final state");

    a_sqrt_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pnn_pkg::ST_FIN) |-> (rem_reg <= (root_reg << 1)))
        else $error("square root remainder out of range");

endmodule

/* rtl/periodic_nearest_neighbor_search.sv */
// Each candidate passes through the back end in order: it is taken from the queue,
// its 21 products go through one shared multiplier as a multiply step and an add step,
// a wrap/round step follows each matrix row, and a compare-and-keep step closes it.
// A run-closing candidate then adds a bit-serial square root and a load of the output
// register, which waits until the output is free. A two-entry queue takes requests while the back end works.
// Reset clears all configuration registers to zero, empties the queue and starts a fresh run.
module periodic_nearest_neighbor_search
(
    input  logic          clk,
    input  logic          rst_n,
    pnn_item_if.sink      item,
    pnn_result_if.source  result,
    pnn_cfg_if.sink       cfg
);

    pnn_pkg::cfg_t      cfg_reg;
    logic               q_valid;
    pnn_pkg::qentry_t   q_data;
    logic               q_pop;

    assign cfg.ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                pnn_pkg::CFG_BOX_ROW_X:  cfg_reg.box[0]  <= cfg.data;
                pnn_pkg::CFG_BOX_ROW_Y:  cfg_reg.box[1]  <= cfg.data;
                pnn_pkg::CFG_BOX_ROW_Z:  cfg_reg.box[2]  <= cfg.data;
                pnn_pkg::CFG_FRAC_COL_X: cfg_reg.frac[0] <= cfg.data;
                pnn_pkg::CFG_FRAC_COL_Y: cfg_reg.frac[1] <= cfg.data;
                pnn_pkg::CFG_FRAC_COL_Z: cfg_reg.frac[2] <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    pnn_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    pnn_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

/* tb/periodic_nearest_neighbor_search_test.sv */
module periodic_nearest_neighbor_search_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic signed [pnn_pkg::COORD_W-1:0] qx, qy, qz, cx, cy, cz;
        logic                               last;
    } cand_req_t;

    typedef struct {
        logic [pnn_pkg::IDX_W-1:0]  index;
        logic [pnn_pkg::DIST_W-1:0] distance;
        logic                       ovf;
    } nearest_t;

    logic clk;
    logic rst_n;

    pnn_item_if   item ();
    pnn_result_if result ();
    pnn_cfg_if    cfg ();

    periodic_nearest_neighbor_search dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    // Pending requests, expected results and the predictor's own copy of state.
    cand_req_t   pending_reqs[$];
    nearest_t    expected_nearest[$];
    logic [pnn_pkg::REG_W-1:0] box_reg[3];
    logic [pnn_pkg::REG_W-1:0] frac_reg[3];
    logic [pnn_pkg::SQ_W-1:0]  run_best_sq;
    int unsigned      run_best_pos;
    int unsigned      run_count;
    bit               run_overflow;
    int               error_count;
    bit               quiet_tail;
    int               item_gap;
    int               result_gap;
    int               idle_cycles;
    bit               drive_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic longint signed field_of(input logic [pnn_pkg::REG_W-1:0] w,
                                               input int c);
        logic signed [pnn_pkg::ENTRY_W-1:0] e;
        e = w[c*pnn_pkg::ENTRY_W +: pnn_pkg::ENTRY_W];
        return longint'(e);
    endfunction

    function automatic longint signed floor_div(input longint signed x, input int s);
        return x >>> s;
    endfunction

    function automatic longint signed round_frac(input longint signed f);
        if (f >= 0)
            return (f + (64'sd1 <<< 19)) >>> 20;
        return -((-f + (64'sd1 <<< 19)) >>> 20);
    endfunction

    // Squared minimum-image distance of one candidate.
    function automatic logic [pnn_pkg::SQ_W-1:0] image_sq_distance(input cand_req_t r);
        longint signed d[3];
        longint signed rem[3];
        longint signed sum;
        longint signed f;
        longint unsigned acc;
        longint unsigned m;
        d[0] = longint'(r.qx) - longint'(r.cx);
        d[1] = longint'(r.qy) - longint'(r.cy);
        d[2] = longint'(r.qz) - longint'(r.cz);
        acc = 0;
        for (int k = 0; k < 3; k++)
        begin
            sum = 0;
            for (int c = 0; c < 3; c++)
                sum += d[c] * field_of(frac_reg[k], c);
            f = floor_div(sum, pnn_pkg::COORD_FRAC_BITS);
            rem[k] = f - round_frac(f) * (64'sd1 <<< 20);
        end
        for (int k = 0; k < 3; k++)
        begin
            sum = 0;
            for (int c = 0; c < 3; c++)
                sum += field_of(box_reg[k], c) * rem[c];
            sum = floor_div(sum + (64'sd1 <<< 19), 20);
            m = longint'(sum < 0 ? -sum : sum);
            acc += m * m;
        end
        if (acc > longint'(pnn_pkg::SQ_MAX))
            return pnn_pkg::SQ_MAX;
        return acc[pnn_pkg::SQ_W-1:0];
    endfunction

    function automatic longint unsigned round_sqrt(input longint unsigned s);
        longint unsigned q;
        longint unsigned b;
        longint unsigned v;
        q = 0;
        v = s;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= q + b)
            begin
                v -= q + b;
                q = (q >> 1) + b;
            end
            else
                q >>= 1;
            b >>= 2;
        end
        if (s - q * q > q)
            q++;
        if (q > pnn_pkg::DIST_MAX)
            q = pnn_pkg::DIST_MAX;
        return q;
    endfunction

    task automatic predict_candidate(input cand_req_t r);
        logic [pnn_pkg::SQ_W-1:0] sq;
        nearest_t n;
        if (run_count < pnn_pkg::MAX_CANDIDATES)
        begin
            sq = image_sq_distance(r);
            if (run_count == 0 || sq < run_best_sq)
            begin
                run_best_sq  = sq;
                run_best_pos = run_count;
            end
            run_count++;
        end
        else
            run_overflow = 1'b1;
        if (r.last)
        begin
            n.index    = run_best_pos[pnn_pkg::IDX_W-1:0];
            n.distance = pnn_pkg::DIST_W'(round_sqrt(run_best_sq));
            n.ovf      = run_overflow;
            expected_nearest = {expected_nearest, n};
            run_best_sq  = pnn_pkg::SQ_MAX;
            run_best_pos = 0;
            run_count    = 0;
            run_overflow = 1'b0;
        end
    endtask

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item.valid <= 1'b0;
            item_gap   <= 0;
        end
        else
        begin
            if (item.valid && item.ready)
            begin
                cand_req_t r;
                r.qx = item.query_x; r.qy = item.query_y; r.qz = item.query_z;
                r.cx = item.cand_x;  r.cy = item.cand_y;  r.cz = item.cand_z;
                r.last = item.last_candidate;
                predict_candidate(r);
            end
            if (!item.valid || item.ready)
            begin
                if (item_gap > 0)
                begin
                    item.valid <= 1'b0;
                    item_gap   <= item_gap - 1;
                end
                else if (pending_reqs.size() > 0 && !quiet_tail
                         && $urandom_range(0, 9) == 0)
                begin
                    item.valid <= 1'b0;
                    item_gap   <= $urandom_range(0, 7);
                end
                else if (pending_reqs.size() > 0)
                begin
                    cand_req_t r;
                    r = pending_reqs.pop_front();
                    item.valid          <= 1'b1;
                    item.query_x        <= r.qx;
                    item.query_y        <= r.qy;
                    item.query_z        <= r.qz;
                    item.cand_x         <= r.cx;
                    item.cand_y         <= r.cy;
                    item.cand_z         <= r.cz;
                    item.last_candidate <= r.last;
                end
                else
                    item.valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            result_gap   <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_nearest.size() == 0)
                begin
                    report_mismatch("unexpected result index", result.nearest_index, -1);
                end
                else
                begin
                    nearest_t n;
                    n = expected_nearest.pop_front();
                    if (result.nearest_index !== n.index)
                        report_mismatch("nearest_index", result.nearest_index, n.index);
                    if (result.nearest_distance !== n.distance)
                        report_mismatch("nearest_distance", result.nearest_distance,
                                        n.distance);
                    if (result.count_overflow !== n.ovf)
                        report_mismatch("count_overflow", result.count_overflow, n.ovf);
                end
            end
            if (result_gap > 0)
            begin
                result.ready <= 1'b0;
                result_gap   <= result_gap - 1;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                result.ready <= 1'b0;
                result_gap   <= $urandom_range(0, 7);
            end
            else
                result.ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any accepted request, result or write.
    always @(posedge clk)
    begin
        if (!rst_n || (item.valid && item.ready) || (result.valid && result.ready)
            || (cfg.valid && cfg.ready) || drive_done)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("periodic_nearest_neighbor_search_test NOT OK");
                $finish;
            end
        end
    end

    // One register write; the channel idles before the task returns.
    task automatic write_reg(input pnn_pkg::cfg_idx_t idx,
                             input logic [pnn_pkg::REG_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx <= pnn_pkg::CFG_BOX_ROW_Z)
            box_reg[idx[1:0]] = value;
        else
            frac_reg[2'(idx - pnn_pkg::CFG_FRAC_COL_X)] = value;
        @(posedge clk);
    endtask

    function automatic logic [pnn_pkg::REG_W-1:0] pack3(input int a, input int b, input int c);
        return {pnn_pkg::ENTRY_W'(c), pnn_pkg::ENTRY_W'(b), pnn_pkg::ENTRY_W'(a)};
    endfunction

    function automatic logic signed [pnn_pkg::COORD_W-1:0] rand_coord(input int span);
        if (span == 0)
            return pnn_pkg::COORD_W'($urandom);
        return pnn_pkg::COORD_W'($urandom_range(0, 2 * span) - span);
    endfunction

    task automatic add_req(input int a, input int b, input int c, input int d,
                           input int e, input int f, input bit last);
        cand_req_t r;
        r.qx = pnn_pkg::COORD_W'(a); r.qy = pnn_pkg::COORD_W'(b);
        r.qz = pnn_pkg::COORD_W'(c); r.cx = pnn_pkg::COORD_W'(d);
        r.cy = pnn_pkg::COORD_W'(e); r.cz = pnn_pkg::COORD_W'(f);
        r.last = last;
        pending_reqs = {pending_reqs, r};
    endtask

    // Wait until the block has drained everything queued so far.
    task automatic drain();
        @(negedge clk);
        while (pending_reqs.size() > 0 || item.valid || expected_nearest.size() > 0)
            @(negedge clk);
        repeat (100) @(posedge clk);
    endtask

    // Random runs of candidates; mostly short, wide coordinates sometimes.
    task automatic random_runs(input int n_items);
        int left;
        int run_len;
        int span;
        int qx, qy, qz;
        left = n_items;
        while (left > 0)
        begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 6);
            span = ($urandom_range(0, 3) == 0) ? 0 : 20000;
            qx = rand_coord(span); qy = rand_coord(span); qz = rand_coord(span);
            for (int i = 0; i < run_len && left > 0; i++, left--)
                add_req(qx, qy, qz, rand_coord(span), rand_coord(span), rand_coord(span),
                        i == run_len - 1 || left == 1);
        end
    endtask

    task automatic load_box(input int a, input int b);
        write_reg(pnn_pkg::CFG_BOX_ROW_X, pack3(a, b, 0));
        write_reg(pnn_pkg::CFG_BOX_ROW_Y, pack3(0, a, 0));
        write_reg(pnn_pkg::CFG_BOX_ROW_Z, pack3(0, b, a));
    endtask

    initial
    begin
        int lim;
        error_count  = 0;
        quiet_tail   = 1'b0;
        drive_done   = 1'b0;
        run_best_sq  = pnn_pkg::SQ_MAX;
        run_best_pos = 0;
        run_count    = 0;
        run_overflow = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            box_reg[i]  = '0;
            frac_reg[i] = '0;
        end
        item.valid = 1'b0; item.last_candidate = 1'b0;
        item.query_x = '0; item.query_y = '0; item.query_z = '0;
        item.cand_x = '0; item.cand_y = '0; item.cand_z = '0;
        result.ready = 1'b0;
        cfg.valid = 1'b0; cfg.index = pnn_pkg::CFG_BOX_ROW_X; cfg.data = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: all-zero matrices first, then a 20 A cubic box.
        add_req(0, 0, 0, 0, 0, 0, 1'b1);
        drain();
        load_box(20480, 0);
        write_reg(pnn_pkg::CFG_FRAC_COL_X, pack3(52, 0, 0));
        write_reg(pnn_pkg::CFG_FRAC_COL_Y, pack3(0, 52, 0));
        write_reg(pnn_pkg::CFG_FRAC_COL_Z, pack3(0, 0, 52));
        add_req(0, 0, 0, 10240, 0, 0, 1'b0);
        add_req(0, 0, 0, -10240, 0, 0, 1'b0);
        add_req(0, 0, 0, 1024, 1024, 1024, 1'b0);
        add_req(0, 0, 0, 1024, 1024, 1024, 1'b1);
        add_req(-1048576, -1048576, -1048576, 1048575, 1048575, 1048575, 1'b0);
        add_req(1048575, 1048575, 1048575, -1048576, -1048576, -1048576, 1'b1);
        add_req(5, 5, 5, 5, 5, 5, 1'b1);
        drain();

        // Extreme matrices: saturating square and all-ones entries.
        write_reg(pnn_pkg::CFG_BOX_ROW_X, {pnn_pkg::REG_W{1'b1}} >> 1);
        write_reg(pnn_pkg::CFG_BOX_ROW_Y, pack3(1048575, 1048575, 1048575));
        write_reg(pnn_pkg::CFG_BOX_ROW_Z, pack3(-1048576, -1048576, -1048576));
        write_reg(pnn_pkg::CFG_FRAC_COL_X, {pnn_pkg::REG_W{1'b1}});
        write_reg(pnn_pkg::CFG_FRAC_COL_Y, pack3(1048575, -1048576, 1048575));
        write_reg(pnn_pkg::CFG_FRAC_COL_Z, pack3(-1048576, 1048575, 0));
        add_req(1048575, -1048576, 0, -1048576, 1048575, 0, 1'b0);
        add_req(100, 200, 300, 0, 0, 0, 1'b1);
        random_runs(60);
        drain();

        // One long run with the nearest candidate deep inside it.
        load_box(20480, 0);
        write_reg(pnn_pkg::CFG_FRAC_COL_X, pack3(52, 0, 0));
        write_reg(pnn_pkg::CFG_FRAC_COL_Y, pack3(0, 52, 0));
        write_reg(pnn_pkg::CFG_FRAC_COL_Z, pack3(0, 0, 52));
        for (int i = 0; i < 600; i++)
            add_req(0, 0, 0, (i == 437) ? 0 : 3000 - (i % 7), 0, 0, i == 599);
        drain();

        // Random phases under several box settings.
        for (int p = 0; p < 4; p++)
        begin
            lim = $urandom_range(1000, 40000);
            load_box(lim, $urandom_range(0, 4000) - 2000);
            write_reg(pnn_pkg::CFG_FRAC_COL_X, pack3($urandom_range(0, 2000), 0,
                                                     $urandom_range(0, 200) - 100));
            write_reg(pnn_pkg::CFG_FRAC_COL_Y, pack3($urandom_range(0, 200) - 100,
                                                     $urandom_range(0, 2000), 0));
            write_reg(pnn_pkg::CFG_FRAC_COL_Z, pack3(0, $urandom_range(0, 200) - 100,
                                                     $urandom_range(0, 2000)));
            if (p == 3)
                quiet_tail = 1'b1;
            random_runs(p == 3 ? 200 : 250);
            drain();
        end
        drive_done = 1'b1;

        if (error_count == 0)
            $display("periodic_nearest_neighbor_search_test OK");
        else
            $display("periodic_nearest_neighbor_search_test NOT OK");
        $finish;
    end

endmodule
